FILE: rtl/core/fbrb_pkg.sv
`timescale 1ns / 1ps
package fbrb_pkg;

  localparam logic [2:0] OP_STORE_DEST = 3'd0;
  localparam logic [2:0] OP_STORE_SRC  = 3'd1;
  localparam logic [2:0] OP_READ_DEST  = 3'd2;
  localparam logic [2:0] OP_PIXEL      = 3'd3;
  localparam logic [2:0] OP_RECT       = 3'd4;
  localparam logic [2:0] OP_CIRCLE     = 3'd5;
  localparam logic [2:0] OP_TILE       = 3'd6;
  localparam logic [2:0] OP_SPRITE     = 3'd7;

  localparam logic [1:0] REG_DEST_WIDTH  = 2'd0;
  localparam logic [1:0] REG_DEST_HEIGHT = 2'd1;
  localparam logic [1:0] REG_SRC_WIDTH   = 2'd2;
  localparam logic [1:0] REG_SRC_HEIGHT  = 2'd3;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 9;

  typedef struct packed {
    logic [2:0]         opcode;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic [31:0]        color;
    logic signed [15:0] span_width;
    logic signed [15:0] span_height;
    logic signed [15:0] src_x;
    logic signed [15:0] src_y;
    logic [14:0]        radius;
  } fbrb_in_t;

  typedef struct packed {
    logic [31:0] pixel;
    logic        out_of_range;
  } fbrb_out_t;

  typedef struct packed {
    logic [31:0] fg;
    logic [31:0] bg;
  } fbrb_blend_req_t;

endpackage

FILE: rtl/core/fbrb_blend.sv
`timescale 1ns / 1ps
module fbrb_blend
  import fbrb_pkg::*;
(
  input  fbrb_blend_req_t req,
  output logic [31:0]     result
);

  function automatic logic [7:0] mix(input logic [7:0] f, input logic [7:0] b,
                                     input logic [7:0] a);
    logic [15:0] s;
    logic [24:0] q;
    s = 16'(a) * 16'(f) + 16'(8'd255 - a) * 16'(b);
    // x/255 for x < 65536: (x*0x8081)>>23
    q = 25'((32'(s) * 32'h8081) >> 23);
    mix = q[7:0];
  endfunction

  assign result = {mix(req.fg[31:24], req.bg[31:24], req.fg[7:0]),
                   mix(req.fg[23:16], req.bg[23:16], req.fg[7:0]),
                   mix(req.fg[15:8],  req.bg[15:8],  req.fg[7:0]),
                   8'hFF};

endmodule

FILE: rtl/core/framebuffer_raster_blend_engine_unit.sv
`timescale 1ns / 1ps
// Framebuffer raster and blend engine. Holds a destination framebuffer and a
// source map in two synchronous RAMs. A store or an out-of-range single-pixel
// command passes S_SETUP then S_DONE, a read S_SETUP, S_READ, S_DONE, and a
// blended pixel S_SETUP, S_READ, S_WRITE (RAM read, then blend and write back),
// S_DONE. Area commands (rect, circle, tile, sprite) pass S_SETUP and S_NEXT,
// then S_READ and S_WRITE per pixel of their bounding box clipped to the images;
// circle pixels outside the radius still pass both. The result waits in S_DONE
// until out_ready, and the block takes no new item before then.
// Every framebuffer entry must be written before it is read.
module framebuffer_raster_blend_engine_unit
  import fbrb_pkg::*;
#(
  parameter int DEST_MAX_WIDTH  = 256,
  parameter int DEST_MAX_HEIGHT = 256,
  parameter int SRC_MAX_WIDTH   = 256,
  parameter int SRC_MAX_HEIGHT  = 256
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  fbrb_in_t              in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output fbrb_out_t             out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int DDEPTH = DEST_MAX_WIDTH * DEST_MAX_HEIGHT;
  localparam int SDEPTH = SRC_MAX_WIDTH * SRC_MAX_HEIGHT;
  localparam int DAW = (DDEPTH > 1) ? $clog2(DDEPTH) : 1;
  localparam int SAW = (SDEPTH > 1) ? $clog2(SDEPTH) : 1;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_SETUP = 6'b000010,
    S_READ  = 6'b000100,
    S_WRITE = 6'b001000,
    S_NEXT  = 6'b010000,
    S_DONE  = 6'b100000
  } state_t;

  state_t state_r, state_nxt;
  logic [CFG_DATA_W-1:0] dw_r, dh_r, sw_r, sh_r;
  fbrb_in_t cmd_r;
  logic signed [17:0] c0_r, c1_r, r0_r, r1_r;
  logic signed [16:0] walk_column_r, walk_row_r;
  logic [31:0] rd_pix_r;
  logic        oor_r;
  logic        draw_r;
  logic [31:0] dmem_q, smem_q;
  logic [31:0] dmem [DDEPTH];
  logic [31:0] smem [SDEPTH];
  logic [31:0] blend_res;
  fbrb_blend_req_t breq;
  logic [29:0] r2_r;

  function automatic logic [CFG_DATA_W-1:0] clampv(input logic [CFG_DATA_W-1:0] v,
                                                    input int mx);
    clampv = (int'(v) > mx) ? CFG_DATA_W'(mx) : v;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dw_r <= clampv(9'd256, DEST_MAX_WIDTH);
      dh_r <= clampv(9'd256, DEST_MAX_HEIGHT);
      sw_r <= clampv(9'd256, SRC_MAX_WIDTH);
      sh_r <= clampv(9'd256, SRC_MAX_HEIGHT);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_DEST_WIDTH:  dw_r <= clampv(cfg_data, DEST_MAX_WIDTH);
        REG_DEST_HEIGHT: dh_r <= clampv(cfg_data, DEST_MAX_HEIGHT);
        REG_SRC_WIDTH:   sw_r <= clampv(cfg_data, SRC_MAX_WIDTH);
        REG_SRC_HEIGHT:  sh_r <= clampv(cfg_data, SRC_MAX_HEIGHT);
        default: ;
      endcase
    end
  end

  // walk: (column,row) in destination coordinates for rect/circle,
  // offsets for tile/sprite
  logic signed [17:0] dx_cur, dy_cur, sx_cur, sy_cur;
  logic is_copy, is_single;
  always_comb begin
    is_copy = (cmd_r.opcode == OP_TILE) || (cmd_r.opcode == OP_SPRITE);
    is_single = (cmd_r.opcode == OP_STORE_DEST) || (cmd_r.opcode == OP_STORE_SRC) ||
                (cmd_r.opcode == OP_READ_DEST) || (cmd_r.opcode == OP_PIXEL);
    if (is_single) begin
      dx_cur = 18'(cmd_r.pos_x);
      dy_cur = 18'(cmd_r.pos_y);
    end else if (is_copy) begin
      dx_cur = 18'(cmd_r.pos_x) + 18'(walk_column_r);
      dy_cur = 18'(cmd_r.pos_y) + 18'(walk_row_r);
    end else begin
      dx_cur = 18'(walk_column_r);
      dy_cur = 18'(walk_row_r);
    end
    sx_cur = is_single ? 18'(cmd_r.pos_x) : 18'(cmd_r.src_x) + 18'(walk_column_r);
    sy_cur = is_single ? 18'(cmd_r.pos_y) : 18'(cmd_r.src_y) + 18'(walk_row_r);
  end

  logic [DAW-1:0] daddr;
  logic [SAW-1:0] saddr;
  logic [17:0] dprod, sprod;
  assign dprod = 18'(dy_cur[8:0]) * 18'(dw_r) + 18'(dx_cur[8:0]);
  assign sprod = 18'(sy_cur[8:0]) * 18'(sw_r) + 18'(sx_cur[8:0]);
  assign daddr = DAW'(dprod);
  assign saddr = SAW'(sprod);

  logic dest_in, src_in;
  assign dest_in = !dx_cur[17] && !dy_cur[17] && (dx_cur < 18'(dw_r)) &&
                   (dy_cur < 18'(dh_r));
  assign src_in = !sx_cur[17] && !sy_cur[17] && (sx_cur < 18'(sw_r)) &&
                  (sy_cur < 18'(sh_r));

  // bounds
  logic signed [17:0] c0_n, c1_n, r0_n, r1_n;
  logic signed [17:0] px, py, rad;
  function automatic logic signed [17:0] smax(input logic signed [17:0] a,
                                               input logic signed [17:0] b);
    smax = (a > b) ? a : b;
  endfunction
  function automatic logic signed [17:0] smin(input logic signed [17:0] a,
                                               input logic signed [17:0] b);
    smin = (a < b) ? a : b;
  endfunction
  always_comb begin
    px  = 18'(cmd_r.pos_x);
    py  = 18'(cmd_r.pos_y);
    rad = 18'(cmd_r.radius);
    c0_n = '0; c1_n = '0; r0_n = '0; r1_n = '0;
    case (cmd_r.opcode)
      OP_RECT: begin
        c0_n = smax(px, 18'sd0);
        c1_n = smin(px + 18'(cmd_r.span_width), 18'(dw_r));
        r0_n = smax(py, 18'sd0);
        r1_n = smin(py + 18'(cmd_r.span_height), 18'(dh_r));
      end
      OP_CIRCLE: begin
        c0_n = smax(px - rad, 18'sd0);
        c1_n = smin(px + rad + 18'sd1, 18'(dw_r));
        r0_n = smax(py - rad, 18'sd0);
        r1_n = smin(py + rad + 18'sd1, 18'(dh_r));
      end
      default: begin
        c0_n = smax(18'sd0, smax(-18'(cmd_r.src_x), -px));
        c1_n = smin(18'(cmd_r.span_width),
                    smin(18'(sw_r) - 18'(cmd_r.src_x), 18'(dw_r) - px));
        r0_n = smax(18'sd0, smax(-18'(cmd_r.src_y), -py));
        r1_n = smin(18'(cmd_r.span_height),
                    smin(18'(sh_r) - 18'(cmd_r.src_y), 18'(dh_r) - py));
      end
    endcase
  end

  logic signed [17:0] ddx, ddy;
  assign ddx = 18'(walk_column_r) - px;
  assign ddy = 18'(walk_row_r) - py;

  logic dwe, swe;
  logic [31:0] dwdata;
  logic [17:0] wc_n;
  logic last_col, empty_box;
  assign wc_n = 18'(walk_column_r) + 18'sd1;
  assign last_col = !(wc_n < c1_r);
  assign empty_box = !(c0_r < c1_r) || !(r0_r < r1_r);

  assign breq.fg = (cmd_r.opcode == OP_SPRITE) ? smem_q : cmd_r.color;
  assign breq.bg = dmem_q;

  fbrb_blend u_blend (.req(breq), .result(blend_res));

  always_comb begin
    state_nxt = state_r;
    dwe = 1'b0;
    swe = 1'b0;
    dwdata = blend_res;
    unique case (state_r)
      S_IDLE:  if (in_valid) state_nxt = S_SETUP;
      S_SETUP: begin
        if (is_single) begin
          if ((cmd_r.opcode == OP_STORE_SRC) ? !src_in : !dest_in) state_nxt = S_DONE;
          else if (cmd_r.opcode == OP_STORE_DEST) begin
            dwe = 1'b1; dwdata = cmd_r.color; state_nxt = S_DONE;
          end else if (cmd_r.opcode == OP_STORE_SRC) begin
            swe = 1'b1; state_nxt = S_DONE;
          end else state_nxt = S_READ;
        end else state_nxt = S_NEXT;
      end
      S_NEXT:  state_nxt = empty_box ? S_DONE : S_READ;
      S_READ:  state_nxt = (is_single && cmd_r.opcode != OP_PIXEL) ? S_DONE : S_WRITE;
      S_WRITE: begin
        if (draw_r && dest_in) begin
          dwe = 1'b1;
          if (cmd_r.opcode == OP_TILE) dwdata = smem_q;
        end
        state_nxt = (is_single || (last_col && !((18'(walk_row_r) + 18'sd1) < r1_r))) ?
                    S_DONE : S_READ;
      end
      S_DONE:  if (out_ready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (dwe) dmem[daddr] <= dwdata;
    dmem_q <= dmem[daddr];
    if (swe) smem[saddr] <= cmd_r.color;
    smem_q <= smem[saddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      walk_column_r <= '0;
      walk_row_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_NEXT) begin
        walk_column_r <= 17'(c0_r);
        walk_row_r <= 17'(r0_r);
      end else if (state_r == S_WRITE) begin
        if (last_col) begin
          walk_column_r <= 17'(c0_r);
          walk_row_r <= walk_row_r + 17'sd1;
        end else walk_column_r <= walk_column_r + 17'sd1;
      end
      if (state_nxt == S_DONE && state_r != S_DONE) begin
        walk_column_r <= '0;
        walk_row_r <= '0;
      end
    end
  end

  // draw decision for current walk pixel (computed during S_READ)
  logic signed [35:0] sq_x, sq_y;
  logic [35:0] dsq;
  assign sq_x = ddx * ddx;
  assign sq_y = ddy * ddy;
  assign dsq = sq_x + sq_y;
  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && in_valid) cmd_r <= in_data;
    if (state_r == S_SETUP) begin
      c0_r <= c0_n; c1_r <= c1_n; r0_r <= r0_n; r1_r <= r1_n;
      r2_r <= 30'(cmd_r.radius) * 30'(cmd_r.radius);
      oor_r <= is_single && ((cmd_r.opcode == OP_STORE_SRC) ? !src_in : !dest_in);
      rd_pix_r <= '0;
    end
    if (state_r == S_READ) begin
      draw_r <= (cmd_r.opcode != OP_CIRCLE) || (dsq <= 36'(r2_r));
      if (is_single && cmd_r.opcode == OP_READ_DEST) rd_pix_r <= dmem_q;
    end
  end

  assign in_ready = (state_r == S_IDLE);
  assign out_valid = (state_r == S_DONE);
  assign out_data.pixel = rd_pix_r;
  assign out_data.out_of_range = oor_r;

  assert property (@(posedge clk) disable iff (!rst_n) out_valid |-> !in_ready)
    else $error("accept while result pending");
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> out_valid) else $error("result dropped");
  assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> (walk_column_r == 0 && walk_row_r == 0)) else $error("walk not cleared");

endmodule

FILE: dv/fbrb_blend_checker.sv
`timescale 1ns / 1ps
module fbrb_blend_checker
  import fbrb_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  fbrb_in_t              in_data,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  fbrb_out_t             out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    mismatches,
  output int                    pending
);

  localparam int MAX_DIM = 256;

  logic [31:0] frame_mem [MAX_DIM*MAX_DIM];
  logic [31:0] src_mem [MAX_DIM*MAX_DIM];
  int fb_w, fb_h, map_w, map_h;
  fbrb_out_t result_q[$];

  initial begin
    for (int i = 0; i < MAX_DIM*MAX_DIM; i++) begin
      frame_mem[i] = '0;
      src_mem[i] = '0;
    end
  end

  function automatic int clamp_dim(logic [CFG_DATA_W-1:0] v);
    return (int'(v) > MAX_DIM) ? MAX_DIM : int'(v);
  endfunction

  function automatic logic [31:0] alpha_mix(logic [31:0] fg, logic [31:0] bg);
    int a;
    logic [31:0] res;
    a = fg[7:0];
    res[7:0] = 8'hff;
    for (int ch = 1; ch < 4; ch++)
      res[ch*8 +: 8] = 8'((a * fg[ch*8 +: 8] + (255 - a) * bg[ch*8 +: 8]) / 255);
    return res;
  endfunction

  function automatic bit in_image(int x, int y, int w, int h);
    return x >= 0 && x < w && y >= 0 && y < h;
  endfunction

  function automatic void blend_at(int x, int y, logic [31:0] fg);
    int addr;
    addr = y * fb_w + x;
    frame_mem[addr] = alpha_mix(fg, frame_mem[addr]);
  endfunction

  function automatic fbrb_out_t run_command(fbrb_in_t c);
    fbrb_out_t r;
    int px, py, sw, sh, sx, sy, x0, x1, y0, y1;
    longint rad, ylo, yhi, xlo, xhi, dx, dy;
    logic [31:0] s;
    r = '0;
    px = c.pos_x; py = c.pos_y; sw = c.span_width; sh = c.span_height;
    sx = c.src_x; sy = c.src_y; rad = c.radius;
    case (c.opcode)
      OP_STORE_DEST, OP_READ_DEST, OP_PIXEL: begin
        if (!in_image(px, py, fb_w, fb_h)) r.out_of_range = 1'b1;
        else if (c.opcode == OP_STORE_DEST) frame_mem[py*fb_w+px] = c.color;
        else if (c.opcode == OP_READ_DEST) r.pixel = frame_mem[py*fb_w+px];
        else blend_at(px, py, c.color);
      end
      OP_STORE_SRC: begin
        if (!in_image(px, py, map_w, map_h)) r.out_of_range = 1'b1;
        else src_mem[py*map_w+px] = c.color;
      end
      OP_RECT: begin
        x0 = (px > 0) ? px : 0;
        x1 = (px + sw < fb_w) ? px + sw : fb_w;
        y0 = (py > 0) ? py : 0;
        y1 = (py + sh < fb_h) ? py + sh : fb_h;
        for (int y = y0; y < y1; y++)
          for (int x = x0; x < x1; x++) blend_at(x, y, c.color);
      end
      OP_CIRCLE: begin
        ylo = py - rad; yhi = py + rad; xlo = px - rad; xhi = px + rad;
        y0 = (ylo < 0) ? 0 : ((ylo > fb_h) ? fb_h : int'(ylo));
        y1 = (yhi >= fb_h) ? fb_h : ((yhi < -1) ? 0 : int'(yhi) + 1);
        x0 = (xlo < 0) ? 0 : ((xlo > fb_w) ? fb_w : int'(xlo));
        x1 = (xhi >= fb_w) ? fb_w : ((xhi < -1) ? 0 : int'(xhi) + 1);
        for (int y = y0; y < y1; y++)
          for (int x = x0; x < x1; x++) begin
            dx = x - px;
            dy = y - py;
            if (dx*dx + dy*dy <= rad*rad) blend_at(x, y, c.color);
          end
      end
      default: begin
        x0 = 0;
        if (-sx > x0) x0 = -sx;
        if (-px > x0) x0 = -px;
        x1 = sw;
        if (map_w - sx < x1) x1 = map_w - sx;
        if (fb_w - px < x1) x1 = fb_w - px;
        y0 = 0;
        if (-sy > y0) y0 = -sy;
        if (-py > y0) y0 = -py;
        y1 = sh;
        if (map_h - sy < y1) y1 = map_h - sy;
        if (fb_h - py < y1) y1 = fb_h - py;
        for (int j = y0; j < y1; j++)
          for (int i = x0; i < x1; i++) begin
            s = src_mem[(sy+j)*map_w + sx + i];
            if (c.opcode == OP_TILE) frame_mem[(py+j)*fb_w + px + i] = s;
            else blend_at(px + i, py + j, s);
          end
      end
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    fbrb_out_t want;
    if (!rst_n) begin
      fb_w <= MAX_DIM; fb_h <= MAX_DIM; map_w <= MAX_DIM; map_h <= MAX_DIM;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_DEST_WIDTH:  fb_w <= clamp_dim(cfg_data);
          REG_DEST_HEIGHT: fb_h <= clamp_dim(cfg_data);
          REG_SRC_WIDTH:   map_w <= clamp_dim(cfg_data);
          REG_SRC_HEIGHT:  map_h <= clamp_dim(cfg_data);
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (result_q.size() == 0) begin
          $error("unexpected result item pixel=%h oor=%b", out_data.pixel,
                 out_data.out_of_range);
          mismatches++;
        end else begin
          want = result_q.pop_front();
          if (out_data.pixel !== want.pixel) begin
            $error("pixel: expected %h actual %h", want.pixel, out_data.pixel);
            mismatches++;
          end
          if (out_data.out_of_range !== want.out_of_range) begin
            $error("out_of_range: expected %b actual %b", want.out_of_range,
                   out_data.out_of_range);
            mismatches++;
          end
        end
      end
      if (in_valid && in_ready) result_q.push_back(run_command(in_data));
      pending = result_q.size();
    end
  end

endmodule

FILE: dv/tb_framebuffer_raster_blend_engine_unit.sv
`timescale 1ns / 1ps
module tb_framebuffer_raster_blend_engine_unit;
  import fbrb_pkg::*;

  localparam int MAX_DIM = 256;
  localparam int CYCLE_LIMIT = 3000000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  fbrb_in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  fbrb_out_t out_data;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  int mismatches, pending;
  int send_idle_pct = 0;
  int stall_pct = 0;
  int cycles = 0;
  int fb_w, fb_h, map_w, map_h;
  bit frame_written [MAX_DIM*MAX_DIM];
  bit src_written [MAX_DIM*MAX_DIM];

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  framebuffer_raster_blend_engine_unit uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  fbrb_blend_checker u_checker (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .mismatches(mismatches), .pending(pending)
  );

  always @(posedge clk) begin
    if (!rst_n) out_ready <= 1'b0;
    else out_ready <= ($urandom_range(0, 99) >= stall_pct);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_framebuffer_raster_blend_engine_unit NOT OK");
      $finish;
    end
  end

  task automatic set_traffic(int mode);
    case (mode % 4)
      0: begin send_idle_pct = 0;  stall_pct = 0;  end
      1: begin send_idle_pct = 45; stall_pct = 0;  end
      2: begin send_idle_pct = 0;  stall_pct = 45; end
      default: begin send_idle_pct = 25; stall_pct = 25; end
    endcase
  endtask

  task automatic send_cmd(fbrb_in_t cmd);
    in_valid <= 1'b1;
    in_data <= cmd;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] v);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    @(posedge clk);
  endtask

  function automatic int clamp_dim(int v);
    return (v > MAX_DIM) ? MAX_DIM : v;
  endfunction

  task automatic configure(int dw, int dh, int sw, int sh);
    write_reg(REG_DEST_WIDTH, CFG_DATA_W'(dw));
    write_reg(REG_DEST_HEIGHT, CFG_DATA_W'(dh));
    write_reg(REG_SRC_WIDTH, CFG_DATA_W'(sw));
    write_reg(REG_SRC_HEIGHT, CFG_DATA_W'(sh));
    cfg_we <= 1'b0;
    fb_w = clamp_dim(dw); fb_h = clamp_dim(dh);
    map_w = clamp_dim(sw); map_h = clamp_dim(sh);
  endtask

  function automatic fbrb_in_t make_cmd(logic [2:0] op, int x, int y, logic [31:0] col,
                                        int w = 0, int h = 0, int sx = 0, int sy = 0,
                                        int rad = 0);
    fbrb_in_t c;
    c.opcode = op; c.pos_x = 16'(x); c.pos_y = 16'(y); c.color = col;
    c.span_width = 16'(w); c.span_height = 16'(h); c.src_x = 16'(sx);
    c.src_y = 16'(sy); c.radius = 15'(rad);
    return c;
  endfunction

  // every in-range entry gets written so later reads never touch stale memory
  task automatic fill_images;
    int addr;
    for (int y = 0; y < fb_h; y++)
      for (int x = 0; x < fb_w; x++) begin
        addr = y * fb_w + x;
        if (!frame_written[addr]) begin
          send_cmd(make_cmd(OP_STORE_DEST, x, y, $urandom()));
          frame_written[addr] = 1'b1;
        end
      end
    for (int y = 0; y < map_h; y++)
      for (int x = 0; x < map_w; x++) begin
        addr = y * map_w + x;
        if (!src_written[addr]) begin
          send_cmd(make_cmd(OP_STORE_SRC, x, y, $urandom()));
          src_written[addr] = 1'b1;
        end
      end
  endtask

  function automatic int near(int lim);
    return $urandom_range(0, lim + 8) - 4;
  endfunction

  function automatic fbrb_in_t random_cmd;
    fbrb_in_t c;
    int big;
    logic [159:0] raw;
    big = (fb_w > map_w) ? fb_w : map_w;
    if ($urandom_range(0, 9) == 0) begin
      raw = {$urandom(), $urandom(), $urandom(), $urandom(), $urandom()};
      c = raw[$bits(fbrb_in_t)-1:0];
    end else begin
      c.opcode = 3'($urandom_range(0, 7));
      c.color = $urandom();
      if ($urandom_range(0, 3) == 0) c.color[7:0] = ($urandom_range(0, 1)) ? 8'hff : 8'h00;
      c.pos_x = 16'(near(fb_w));
      c.pos_y = 16'(near(fb_h));
      c.src_x = 16'(near(map_w));
      c.src_y = 16'(near(map_h));
      c.span_width = 16'(int'($urandom_range(0, big + 4)) - 3);
      c.span_height = 16'(int'($urandom_range(0, big + 4)) - 3);
      c.radius = 15'($urandom_range(0, (fb_h > 12 ? 12 : fb_h) + 2));
      if (c.opcode == OP_STORE_SRC) begin
        c.pos_x = 16'(near(map_w));
        c.pos_y = 16'(near(map_h));
      end
    end
    return c;
  endfunction

  task automatic run_random(int count, int phase);
    for (int i = 0; i < count; i++) begin
      if (i % 40 == 0) set_traffic(phase + i / 40);
      send_cmd(random_cmd());
    end
  endtask

  task automatic run_directed;
    send_cmd(make_cmd(OP_STORE_DEST, 0, 0, 32'h11223344));
    send_cmd(make_cmd(OP_STORE_DEST, 7, 7, 32'hffffffff));
    send_cmd(make_cmd(OP_STORE_DEST, 8, 0, 32'h12345678));
    send_cmd(make_cmd(OP_STORE_DEST, -1, 3, 32'h0));
    send_cmd(make_cmd(OP_STORE_DEST, -32768, 32767, 32'h0));
    send_cmd(make_cmd(OP_STORE_SRC, 7, 7, 32'h80402010));
    send_cmd(make_cmd(OP_STORE_SRC, 0, 8, 32'h1));
    send_cmd(make_cmd(OP_READ_DEST, 7, 7, 32'h0));
    send_cmd(make_cmd(OP_READ_DEST, 8, 8, 32'h0));
    send_cmd(make_cmd(OP_PIXEL, 0, 0, 32'hffffff00));
    send_cmd(make_cmd(OP_PIXEL, 0, 0, 32'habcdefff));
    send_cmd(make_cmd(OP_PIXEL, 7, 7, 32'h00000080));
    send_cmd(make_cmd(OP_PIXEL, 32767, 0, 32'h0));
    send_cmd(make_cmd(OP_READ_DEST, 0, 0, 32'h0));
    send_cmd(make_cmd(OP_RECT, 0, 0, 32'h55aa55c0, -32768, 8));
    send_cmd(make_cmd(OP_RECT, -3, -2, 32'h20406080, 32767, 32767));
    send_cmd(make_cmd(OP_RECT, 5, 6, 32'hff000040, 10, 10));
    send_cmd(make_cmd(OP_CIRCLE, 3, 3, 32'h00ff00ff, 0, 0, 0, 0, 0));
    send_cmd(make_cmd(OP_CIRCLE, 4, 4, 32'h0000ff7f, 0, 0, 0, 0, 32767));
    send_cmd(make_cmd(OP_CIRCLE, -2, 9, 32'h12345699, 0, 0, 0, 0, 4));
    send_cmd(make_cmd(OP_TILE, 0, 0, 32'h0, 8, 8, 0, 0));
    send_cmd(make_cmd(OP_TILE, 2, 2, 32'h0, -1, 5, 0, 0));
    send_cmd(make_cmd(OP_TILE, -2, 3, 32'h0, 32767, 32767, 4, -3));
    send_cmd(make_cmd(OP_SPRITE, 1, -1, 32'h0, 6, 6, -32768, 2));
    send_cmd(make_cmd(OP_SPRITE, 3, 2, 32'h0, 5, 4, 2, 3));
    send_cmd(make_cmd(OP_READ_DEST, 4, 4, 32'h0));
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    set_traffic(0);
    configure(8, 8, 8, 8);
    fill_images();
    run_directed();
    run_random(60, 0);
    drain();

    configure(256, 1, 16, 2);
    fill_images();
    run_random(60, 1);
    drain();

    configure(1, 1, 1, 1);
    fill_images();
    run_random(50, 2);
    drain();

    configure(0, 5, 4, 0);
    run_random(50, 3);
    drain();

    configure(511, 1, 1, 511);
    fill_images();
    run_random(60, 0);
    drain();

    configure(12, 10, 7, 9);
    fill_images();
    run_random(80, 1);
    drain();

    repeat (20) @(posedge clk);
    if (mismatches == 0 && pending == 0)
      $display("tb_framebuffer_raster_blend_engine_unit OK");
    else
      $display("tb_framebuffer_raster_blend_engine_unit NOT OK");
    $finish;
  end

endmodule
